FILE: rtl/fct_pkg.sv
// ----------------------------------------------------------------------------
// fct_pkg
// Shared types and constants of the frustum cull test block: plane register
// layout, query word layout, stage control and arithmetic widths.
// ----------------------------------------------------------------------------
package fct_pkg;

   // plane registers and plane slots
   localparam int PLANE_REGS      = 6;
   localparam int PLANE_COUNT_DEF = 6;
   localparam int PLANE_IDX_W     = $clog2(PLANE_REGS);

   // configuration port
   localparam int CSR_DATA_W = 64;
   localparam int CSR_LSB    = 3;                      // 8 bytes per register
   localparam int CSR_ADDR_W = CSR_LSB + PLANE_IDX_W;

   // field widths and fixed point alignment
   localparam int OP_W       = 2;
   localparam int COORD_W    = 16;
   localparam int RAD_W      = 15;
   localparam int FRAC_SHIFT = 14;                     // Q12.4 -> Q.18
   localparam int PROD_W     = 2 * COORD_W;
   localparam int DIST_W     = PROD_W + 3;

   // stream words
   localparam int REQ_TDATA_W = 112;
   localparam int REQ_TUSER_W = OP_W;
   localparam int RSP_TDATA_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_POINT   = 2'd0,
      OP_SPHERE  = 2'd1,
      OP_BOX     = 2'd2,
      OP_BOX_ALT = 2'd3
   } op_type;

   // register layout: nx in the low bits, offset d in the high bits
   typedef struct packed {
      logic signed [COORD_W-1:0] d;
      logic signed [COORD_W-1:0] nz;
      logic signed [COORD_W-1:0] ny;
      logic signed [COORD_W-1:0] nx;
   } plane_type;

   typedef struct packed {
      logic                      box;
      logic signed [COORD_W-1:0] lo_x;
      logic signed [COORD_W-1:0] lo_y;
      logic signed [COORD_W-1:0] lo_z;
      logic signed [COORD_W-1:0] hi_x;
      logic signed [COORD_W-1:0] hi_y;
      logic signed [COORD_W-1:0] hi_z;
   } query_type;

   typedef struct packed {
      logic s1_load;
      logic s2_load;
   } stage_ctl_type;

endpackage

FILE: rtl/fct_csr.sv
// ----------------------------------------------------------------------------
// fct_csr
// Plane register file behind the configuration port. Six 64-bit registers,
// one per plane, written and read back through the port.
// ----------------------------------------------------------------------------
module fct_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fct_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fct_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready,
   output fct_pkg::plane_type              plane_out [fct_pkg::PLANE_REGS]
);

   logic [fct_pkg::CSR_DATA_W-1:0]  plane_ff [fct_pkg::PLANE_REGS];
   logic [fct_pkg::PLANE_IDX_W-1:0] reg_idx;
   logic                            idx_ok;
   logic                            wr_en;

   assign reg_idx    = csr_paddr[fct_pkg::CSR_ADDR_W-1:fct_pkg::CSR_LSB];
   assign idx_ok     = (32'(reg_idx) < fct_pkg::PLANE_REGS);
   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready && idx_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < fct_pkg::PLANE_REGS; i++) begin
            plane_ff[i] <= '0;
         end
      end else if (wr_en) begin
         plane_ff[reg_idx] <= csr_pwdata;
      end
   end

   // unmapped addresses read as zero
   always_comb begin
      csr_prdata = '0;
      if (idx_ok) begin
         csr_prdata = plane_ff[reg_idx];
      end
   end

   always_comb begin
      for (int i = 0; i < fct_pkg::PLANE_REGS; i++) begin
         plane_out[i] = fct_pkg::plane_type'(plane_ff[i]);
      end
   end

endmodule

FILE: rtl/fct_plane.sv
// ----------------------------------------------------------------------------
// fct_plane
// One plane of the test: vertex choice and three products in the first
// stage, distance sum plus offset and radius bias with sign test in the next.
// ----------------------------------------------------------------------------
module fct_plane (
   input  logic                          clock,
   input  fct_pkg::stage_ctl_type        ctl,
   input  fct_pkg::plane_type            plane,
   input  fct_pkg::query_type            query,
   input  logic [fct_pkg::RAD_W-1:0]     bias,
   output logic                          reject
);

   logic signed [fct_pkg::COORD_W-1:0] vx, vy, vz;
   logic signed [fct_pkg::PROD_W-1:0]  prod_x_in, prod_y_in, prod_z_in;
   logic signed [fct_pkg::PROD_W-1:0]  prod_x_ff, prod_y_ff, prod_z_ff;
   logic signed [fct_pkg::DIST_W-1:0]  offset_term, bias_term, dist_sum;
   logic                               reject_in, reject_ff;

   // positive vertex: max where the normal component is not negative
   always_comb begin
      vx = (query.box && !plane.nx[fct_pkg::COORD_W-1]) ? query.hi_x : query.lo_x;
      vy = (query.box && !plane.ny[fct_pkg::COORD_W-1]) ? query.hi_y : query.lo_y;
      vz = (query.box && !plane.nz[fct_pkg::COORD_W-1]) ? query.hi_z : query.lo_z;
      prod_x_in = plane.nx * vx;
      prod_y_in = plane.ny * vy;
      prod_z_in = plane.nz * vz;
   end

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         prod_z_ff <= prod_z_in;
      end
   end

   // n.v + d + radius < 0 rejects; bias is zero for point and box queries
   always_comb begin
      offset_term = fct_pkg::DIST_W'(plane.d) <<< fct_pkg::FRAC_SHIFT;
      bias_term   = $signed({{(fct_pkg::DIST_W - fct_pkg::RAD_W - fct_pkg::FRAC_SHIFT){1'b0}},
                             bias, {fct_pkg::FRAC_SHIFT{1'b0}}});
      dist_sum    = fct_pkg::DIST_W'(prod_x_ff) + fct_pkg::DIST_W'(prod_y_ff)
                  + fct_pkg::DIST_W'(prod_z_ff) + offset_term + bias_term;
      reject_in   = dist_sum[fct_pkg::DIST_W-1];
   end

   always_ff @(posedge clock) begin
      if (ctl.s2_load) begin
         reject_ff <= reject_in;
      end
   end

   assign reject = reject_ff;

endmodule

FILE: rtl/frustum_cull_test_top.sv
// ----------------------------------------------------------------------------
// frustum_cull_test_top
// Frustum cull test of a point, sphere or box against the plane registers.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tuser: operation; tdata: position,
//                                        box max, radius
//   rsp      out  rsp_tvalid/rsp_tready  tdata: inside_res
//   csr      in   psel/penable/pready    six 64-bit plane registers at 8*i
//
// One word per cycle is taken while rsp_tready holds; four register stages
// (input, product, plane distance, output) carry each word to its result.
// The 16x16 product per plane and axis fixes the stage cut.
// Reset clears all stage valid bits and the plane registers.
// A stall holds, in the same cycle, each full stage with no empty stage after
// it and releases them together; empty stages fill, so bubbles are squeezed out.
// ----------------------------------------------------------------------------
module frustum_cull_test_top #(
   parameter int PLANE_COUNT = fct_pkg::PLANE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // tuser: operation [1:0]
   // tdata: pos_x [15:0], pos_y [31:16], pos_z [47:32], box_max_x [63:48],
   //        box_max_y [79:64], box_max_z [95:80], radius [110:96], zero [111]
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [fct_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic [fct_pkg::REQ_TUSER_W-1:0]   req_tuser,
   // tdata: inside_res [0], zero [7:1]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [fct_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fct_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fct_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [fct_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int CW = fct_pkg::COORD_W;

   fct_pkg::plane_type      planes [fct_pkg::PLANE_REGS];
   fct_pkg::stage_ctl_type  ctl;
   fct_pkg::op_type         op;
   fct_pkg::query_type      query_in, query_ff;

   logic                    v0_ff, v1_ff, v2_ff, v3_ff;
   logic                    rdy0, rdy1, rdy2, rdy3;
   logic [fct_pkg::RAD_W-1:0] rad_in, rad_ff, bias_in, bias_ff;
   logic                    sphere_ff;
   logic [PLANE_COUNT-1:0]  reject;
   logic                    inside_ff;

   fct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .plane_out   (planes)
   );

   // backward ready chain, one term per stage
   assign rdy3       = rsp_tready || !v3_ff;
   assign rdy2       = rdy3 || !v2_ff;
   assign rdy1       = rdy2 || !v1_ff;
   assign rdy0       = rdy1 || !v0_ff;
   assign req_tready = rdy0;

   assign ctl.s1_load = rdy1 && v0_ff;
   assign ctl.s2_load = rdy2 && v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy0) begin
            v0_ff <= req_tvalid;
         end
         if (rdy1) begin
            v1_ff <= v0_ff;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // input stage: unpack the word
   always_comb begin
      op             = fct_pkg::op_type'(req_tuser);
      query_in.box   = (op == fct_pkg::OP_BOX) || (op == fct_pkg::OP_BOX_ALT);
      query_in.lo_x  = req_tdata[0*CW +: CW];
      query_in.lo_y  = req_tdata[1*CW +: CW];
      query_in.lo_z  = req_tdata[2*CW +: CW];
      query_in.hi_x  = req_tdata[3*CW +: CW];
      query_in.hi_y  = req_tdata[4*CW +: CW];
      query_in.hi_z  = req_tdata[5*CW +: CW];
      rad_in         = req_tdata[6*CW +: fct_pkg::RAD_W];
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_tvalid) begin
         query_ff  <= query_in;
         rad_ff    <= rad_in;
         sphere_ff <= (op == fct_pkg::OP_SPHERE);
      end
   end

   assign bias_in = sphere_ff ? rad_ff : '0;

   always_ff @(posedge clock) begin
      if (ctl.s1_load) begin
         bias_ff <= bias_in;
      end
   end

   for (genvar i = 0; i < PLANE_COUNT; i++) begin : g_plane
      if (i < fct_pkg::PLANE_REGS) begin : g_live
         fct_plane u_plane (
            .clock  (clock),
            .ctl    (ctl),
            .plane  (planes[i]),
            .query  (query_ff),
            .bias   (bias_ff),
            .reject (reject[i])
         );
      end else begin : g_none
         // slot without a register never rejects
         assign reject[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         inside_ff <= ~|reject;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {{(fct_pkg::RSP_TDATA_W-1){1'b0}}, inside_ff};

`ifndef ASSERT_OFF
   // a full pipe with a stalled output must hold off the input
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (v0_ff && v1_ff && v2_ff && v3_ff && !rsp_tready) |-> !req_tready)
      else $error("input taken while every stage is full and output stalled");

   // an accepted word lands in the input stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v0_ff)
      else $error("accepted word lost at input stage");

   // a held product stage keeps its radius bias
   a_hold_bias: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && !rdy2) |=> (v1_ff && $stable(bias_ff)))
      else $error("stalled product stage changed");

   // a new result only comes from a valid distance stage
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(v2_ff))
      else $error("result appeared without a word behind it");
`endif

endmodule
